// ===== rtl/wsp_pkg.sv =====
// Package for the weighted sample prediction block: payload words, coefficients and codes.
`default_nettype none

package wsp_pkg;

  localparam int LANES    = 4;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int LOG2_W   = 4;
  localparam int PIX_W    = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int BIAS_W   = 25;
  localparam int SUM_W    = PROD_W + 3;
  localparam int SHIFT_W  = LOG2_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic signed [BIAS_W-1:0] DEF_UNI_BIAS  = BIAS_W'(32);
  localparam logic signed [BIAS_W-1:0] DEF_BI_BIAS   = BIAS_W'(64);
  localparam logic [SHIFT_W-1:0]       DEF_UNI_SHIFT = SHIFT_W'(6);
  localparam logic [SHIFT_W-1:0]       DEF_BI_SHIFT  = SHIFT_W'(7);
  localparam logic [PIX_W-1:0]         PIX_MAX       = '1;

  typedef enum logic [1:0] {
    MODE_DEF_UNI = 2'd0,
    MODE_DEF_BI  = 2'd1,
    MODE_EXP_UNI = 2'd2,
    MODE_EXP_BI  = 2'd3
  } pred_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRED_MODE   = 3'd0,
    CFG_WEIGHT_ZERO = 3'd1,
    CFG_OFFSET_ZERO = 3'd2,
    CFG_WEIGHT_ONE  = 3'd3,
    CFG_OFFSET_ONE  = 3'd4,
    CFG_LOG2_DENOM  = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first_s0;
    logic signed [SAMPLE_W-1:0] first_s1;
    logic signed [SAMPLE_W-1:0] first_s2;
    logic signed [SAMPLE_W-1:0] first_s3;
    logic signed [SAMPLE_W-1:0] second_s0;
    logic signed [SAMPLE_W-1:0] second_s1;
    logic signed [SAMPLE_W-1:0] second_s2;
    logic signed [SAMPLE_W-1:0] second_s3;
  } wsp_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix0;
    logic [PIX_W-1:0] pix1;
    logic [PIX_W-1:0] pix2;
    logic [PIX_W-1:0] pix3;
  } wsp_out_t;

  // Coefficients that every mode reduces to.
  typedef struct packed {
    logic signed [COEF_W-1:0] w0;
    logic signed [COEF_W-1:0] w1;
    logic signed [BIAS_W-1:0] bias;
    logic [SHIFT_W-1:0]       shift;
    logic signed [COEF_W-1:0] offset;
  } coef_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } pipe_en_t;

endpackage

`default_nettype wire

// ===== rtl/wsp_lane.sv =====
// One lane of the weighting datapath: multiply stage, then sum and arithmetic shift stage.
`default_nettype none

module wsp_lane
  import wsp_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic signed [SAMPLE_W-1:0] first_i,
  input  wire logic signed [SAMPLE_W-1:0] second_i,
  input  wire coef_t                      coef_i,
  input  wire pipe_en_t                   en_i,
  output logic signed [SUM_W-1:0]         scaled_o
);

  logic signed [PROD_W-1:0] prod0_q, prod1_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  scaled_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod0_q <= PROD_W'(first_i) * PROD_W'(coef_i.w0);
      prod1_q <= PROD_W'(second_i) * PROD_W'(coef_i.w1);
    end
  end

  // Rounding bias (in explicit bi it also holds the offsets) is folded into one add before the shift.
  always_comb begin
    sum_d = SUM_W'(prod0_q) + SUM_W'(prod1_q) + SUM_W'(coef_i.bias);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      scaled_q <= sum_d >>> coef_i.shift;
    end
  end

  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

// ===== rtl/wsp_merge.sv =====
// Output stage: adds the post-shift offset, clips each lane and packs the result word.
`default_nettype none

module wsp_merge
  import wsp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     load_i,
  input  wire logic signed [SUM_W-1:0]  scaled_i [LANES],
  input  wire logic signed [COEF_W-1:0] offset_i,
  output wsp_out_t                      data_o
);

  logic [PIX_W-1:0] pix_d [LANES];
  logic [PIX_W-1:0] pix_q [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_clip
    logic signed [SUM_W:0] biased;

    always_comb begin
      biased = (SUM_W+1)'(scaled_i[i]) + (SUM_W+1)'(offset_i);
      if (biased < 0) begin
        pix_d[i] = '0;
      end else if (biased > (SUM_W+1)'(PIX_MAX)) begin
        pix_d[i] = PIX_MAX;
      end else begin
        pix_d[i] = biased[PIX_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        pix_q[i] <= pix_d[i];
      end
    end
  end

  assign data_o = '{pix0: pix_q[0], pix1: pix_q[1], pix2: pix_q[2], pix3: pix_q[3]};

endmodule

`default_nettype wire

// ===== rtl/weighted_sample_prediction_top.sv =====
// Top level of the weighted sample prediction block: configuration, lanes and pipeline control.
// Usage notes.
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one word of four list 0 and
// four list 1 intermediate samples; the output channel (out_valid_o, out_stall_i,
// out_data_o) gives one word of four clipped 8-bit pixels for each input word, in order.
// A word moves on a rising edge at which valid is high and stall is low.
// The four lanes run side by side through three register stages: multiply, sum and
// shift, then offset, clip and the output register. One word can be accepted in every
// cycle in which in_stall_o is low.
// Each stage loads whenever it is empty or the stage after it moves on, so bubbles in
// the pipeline are squeezed out while the receiver stalls; in_stall_o rises only when
// all three stages hold words and out_stall_i is high.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready. Indices 0 to 5 select mode, weight zero, offset zero, weight one, offset one and
// log2 denominator; other indices are ignored. Registers should be written only while
// no word is in flight.
// Reset clears the pipeline and puts the registers into default uni mode with unit
// weights, zero offsets and a log2 denominator of six.
`default_nettype none

module weighted_sample_prediction_top
  import wsp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire wsp_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output wsp_out_t                   out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  pred_mode_e               pred_mode_q;
  logic signed [COEF_W-1:0] weight_zero_q, offset_zero_q;
  logic signed [COEF_W-1:0] weight_one_q, offset_one_q;
  logic [LOG2_W-1:0]        log2_denom_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_mode_q   <= MODE_DEF_UNI;
      weight_zero_q <= COEF_W'(1);
      offset_zero_q <= '0;
      weight_one_q  <= COEF_W'(1);
      offset_one_q  <= '0;
      log2_denom_q  <= LOG2_W'(6);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PRED_MODE:   pred_mode_q   <= pred_mode_e'(cfg_data_i[1:0]);
        CFG_WEIGHT_ZERO: weight_zero_q <= cfg_data_i;
        CFG_OFFSET_ZERO: offset_zero_q <= cfg_data_i;
        CFG_WEIGHT_ONE:  weight_one_q  <= cfg_data_i;
        CFG_OFFSET_ONE:  offset_one_q  <= cfg_data_i;
        CFG_LOG2_DENOM:  log2_denom_q  <= cfg_data_i[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Every mode is reduced to ((a*w0 + b*w1 + bias) >>> shift) + offset. Default modes are the
  // explicit ones with w = 1, o = 0, log2 denominator 6; explicit bi keeps offsets in the bias.
  coef_t                    coef;
  logic signed [COEF_W+1:0] off_sum;

  always_comb begin
    off_sum = (COEF_W+2)'(offset_zero_q) + (COEF_W+2)'(offset_one_q) + (COEF_W+2)'(1);
    coef    = '0;
    case (pred_mode_q)
      MODE_DEF_UNI: begin
        coef.w0    = COEF_W'(1);
        coef.bias  = DEF_UNI_BIAS;
        coef.shift = DEF_UNI_SHIFT;
      end
      MODE_DEF_BI: begin
        coef.w0    = COEF_W'(1);
        coef.w1    = COEF_W'(1);
        coef.bias  = DEF_BI_BIAS;
        coef.shift = DEF_BI_SHIFT;
      end
      MODE_EXP_UNI: begin
        coef.w0     = weight_zero_q;
        coef.shift  = SHIFT_W'(log2_denom_q);
        coef.offset = offset_zero_q;
        if (log2_denom_q != '0) begin
          coef.bias = BIAS_W'(1) <<< (log2_denom_q - LOG2_W'(1));
        end
      end
      MODE_EXP_BI: begin
        coef.w0    = weight_zero_q;
        coef.w1    = weight_one_q;
        coef.bias  = BIAS_W'(off_sum) <<< log2_denom_q;
        coef.shift = SHIFT_W'(log2_denom_q) + SHIFT_W'(1);
      end
      default: ;
    endcase
  end

  // Pipeline occupancy and the ready chain from the output back to the input.
  logic     mul_valid_q, sum_valid_q, out_valid_q;
  logic     mul_rdy, sum_rdy, out_rdy;
  pipe_en_t pipe_en;

  assign out_rdy    = !out_valid_q || !out_stall_i;
  assign sum_rdy    = !sum_valid_q || out_rdy;
  assign mul_rdy    = !mul_valid_q || sum_rdy;
  assign in_stall_o = !mul_rdy;

  assign pipe_en.mul_en = mul_rdy;
  assign pipe_en.sum_en = sum_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_valid_q <= in_valid_i;
      end
      if (sum_rdy) begin
        sum_valid_q <= mul_valid_q;
      end
      if (out_rdy) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Unpack the input word into per-lane samples.
  logic signed [SAMPLE_W-1:0] first_lane  [LANES];
  logic signed [SAMPLE_W-1:0] second_lane [LANES];
  logic signed [SUM_W-1:0]    scaled_lane [LANES];

  assign first_lane[0]  = in_data_i.first_s0;
  assign first_lane[1]  = in_data_i.first_s1;
  assign first_lane[2]  = in_data_i.first_s2;
  assign first_lane[3]  = in_data_i.first_s3;
  assign second_lane[0] = in_data_i.second_s0;
  assign second_lane[1] = in_data_i.second_s1;
  assign second_lane[2] = in_data_i.second_s2;
  assign second_lane[3] = in_data_i.second_s3;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    wsp_lane u_lane (
      .clk_i    (clk_i),
      .first_i  (first_lane[i]),
      .second_i (second_lane[i]),
      .coef_i   (coef),
      .en_i     (pipe_en),
      .scaled_o (scaled_lane[i])
    );
  end

  wsp_merge u_merge (
    .clk_i    (clk_i),
    .load_i   (out_rdy),
    .scaled_i (scaled_lane),
    .offset_i (coef.offset),
    .data_o   (out_data_o)
  );

  // An accepted word always lands in the multiply stage.
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> mul_valid_q)
    else $error("accepted word did not enter the multiply stage");

  // Back-pressure only starts at the output.
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output was free");

  // A word in the sum stage reaches an empty output register on the next edge.
  a_sum_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid_q && !out_valid_q |=> out_valid_o)
    else $error("word lost between sum stage and output register");

endmodule

`default_nettype wire

// ===== bench/wsp_checker.sv =====
// Checker for the weighted sample prediction block: tracks the registers, predicts pixels, compares.
`timescale 1ns / 100ps

module wsp_checker
  import wsp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire wsp_in_t               in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire wsp_out_t              out_data_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  // Shadow copy of the weighting registers.
  pred_mode_e               mode_q;
  logic signed [COEF_W-1:0] weight_zero_q;
  logic signed [COEF_W-1:0] offset_zero_q;
  logic signed [COEF_W-1:0] weight_one_q;
  logic signed [COEF_W-1:0] offset_one_q;
  logic [LOG2_W-1:0]        log2_denom_q;

  wsp_out_t pix_due_q[$];

  // One lane, computed at full width and clipped to a pixel.
  function automatic logic [PIX_W-1:0] weigh_lane(input logic signed [SAMPLE_W-1:0] a_s,
                                                   input logic signed [SAMPLE_W-1:0] b_s);
    longint a;
    longint b;
    longint acc;
    longint unit;
    a    = a_s;
    b    = b_s;
    unit = longint'(1) << log2_denom_q;
    case (mode_q)
      MODE_DEF_UNI: acc = (a + 32) >>> 6;
      MODE_DEF_BI:  acc = (a + b + 64) >>> 7;
      MODE_EXP_UNI: begin
        if (log2_denom_q != '0) begin
          acc = ((a * weight_zero_q + unit / 2) >>> log2_denom_q) + offset_zero_q;
        end else begin
          acc = a * weight_zero_q + offset_zero_q;
        end
      end
      default: begin
        acc = (a * weight_zero_q + b * weight_one_q
               + (longint'(offset_zero_q) + offset_one_q + 1) * unit) >>> (log2_denom_q + 1);
      end
    endcase
    if (acc < 0) return '0;
    if (acc > longint'(PIX_MAX)) return PIX_MAX;
    return PIX_W'(acc);
  endfunction

  function automatic wsp_out_t predict_pixels(input wsp_in_t w);
    wsp_out_t p;
    p.pix0 = weigh_lane(w.first_s0, w.second_s0);
    p.pix1 = weigh_lane(w.first_s1, w.second_s1);
    p.pix2 = weigh_lane(w.first_s2, w.second_s2);
    p.pix3 = weigh_lane(w.first_s3, w.second_s3);
    return p;
  endfunction

  task automatic check_pix(input string name, input logic [PIX_W-1:0] want,
                           input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wsp_out_t due;
    if (!rst_ni) begin
      mode_q        = MODE_DEF_UNI;
      weight_zero_q = 8'sd1;
      offset_zero_q = '0;
      weight_one_q  = 8'sd1;
      offset_one_q  = '0;
      log2_denom_q  = 4'd6;
      pix_due_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pix_due_q.size() == 0) begin
          $error("pixel word with nothing expected: %h", out_data_i);
          fail_count_o++;
        end else begin
          due = pix_due_q.pop_front();
          check_pix("pix0", due.pix0, out_data_i.pix0);
          check_pix("pix1", due.pix1, out_data_i.pix1);
          check_pix("pix2", due.pix2, out_data_i.pix2);
          check_pix("pix3", due.pix3, out_data_i.pix3);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pix_due_q.push_back(predict_pixels(in_data_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PRED_MODE:   mode_q        = pred_mode_e'(cfg_data_i[1:0]);
          CFG_WEIGHT_ZERO: weight_zero_q = cfg_data_i;
          CFG_OFFSET_ZERO: offset_zero_q = cfg_data_i;
          CFG_WEIGHT_ONE:  weight_one_q  = cfg_data_i;
          CFG_OFFSET_ONE:  offset_one_q  = cfg_data_i;
          CFG_LOG2_DENOM:  log2_denom_q  = cfg_data_i[LOG2_W-1:0];
          default: ;
        endcase
      end
      pending_o = pix_due_q.size();
    end
  end

endmodule

// ===== bench/tb_weighted_sample_prediction_top.sv =====
// Testbench top for the weighted sample prediction block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_weighted_sample_prediction_top;
  import wsp_pkg::*;

  // Indices beyond the last register; writes to them must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int DRAIN_CYCLES   = 6;     // idle time after the last pixel word, before registers change
  localparam int HOLD_CYCLES    = 120;   // length of the long receiver hold-off
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any word moving
  localparam int RAND_PHASES    = 13;
  localparam int PHASE_WORDS    = 100;

  // One complete weighting setting, written register by register.
  typedef struct {
    pred_mode_e               mode;
    logic signed [COEF_W-1:0] w0;
    logic signed [COEF_W-1:0] o0;
    logic signed [COEF_W-1:0] w1;
    logic signed [COEF_W-1:0] o1;
    logic [LOG2_W-1:0]        l2;
  } weighting_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  wsp_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  wsp_out_t              out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;

  // Shared between the stimulus and the receiver: a calm stretch switches off all random
  // idling, and each new hold ticket asks the receiver for one long hold-off.
  bit calm;
  int hold_ticket;

  weighted_sample_prediction_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  wsp_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most samples sit in the usual intermediate range, so that the pixels land inside
  // 0..255 often enough; a quarter are arbitrary 16-bit patterns to reach the clip and
  // every bit of the field.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
    v = int'($urandom_range(0, 20479)) - 4096;
    return SAMPLE_W'(v);
  endfunction

  function automatic wsp_in_t random_word();
    wsp_in_t w;
    w.first_s0  = pick_sample();
    w.first_s1  = pick_sample();
    w.first_s2  = pick_sample();
    w.first_s3  = pick_sample();
    w.second_s0 = pick_sample();
    w.second_s1 = pick_sample();
    w.second_s2 = pick_sample();
    w.second_s3 = pick_sample();
    return w;
  endfunction

  function automatic weighting_t make_setting(input pred_mode_e mode, input int w0, input int o0,
                                              input int w1, input int o1, input int l2);
    weighting_t s;
    s.mode = mode;
    s.w0   = COEF_W'(w0);
    s.o0   = COEF_W'(o0);
    s.w1   = COEF_W'(w1);
    s.o1   = COEF_W'(o1);
    s.l2   = LOG2_W'(l2);
    return s;
  endfunction

  // Half of the random settings look like a real encoder's: a denominator of 6 to 12
  // with weights close to unity and small offsets. The rest are arbitrary.
  function automatic weighting_t random_setting();
    weighting_t s;
    int d;
    s.mode = pred_mode_e'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) begin
      d    = $urandom_range(0, 6);
      s.l2 = LOG2_W'(d + 6);
      s.w0 = COEF_W'((1 << d) + int'($urandom_range(0, 16)) - 8);
      s.w1 = COEF_W'((1 << d) + int'($urandom_range(0, 16)) - 8);
      s.o0 = COEF_W'(int'($urandom_range(0, 32)) - 16);
      s.o1 = COEF_W'(int'($urandom_range(0, 32)) - 16);
    end else begin
      s.l2 = LOG2_W'($urandom);
      s.w0 = COEF_W'($urandom);
      s.w1 = COEF_W'($urandom);
      s.o0 = COEF_W'($urandom);
      s.o1 = COEF_W'($urandom);
    end
    return s;
  endfunction

  // Offers one word from the next falling edge and returns at the rising edge where it
  // is taken. Valid stays high between back-to-back words; during an idle cycle the data
  // bus carries noise, which the block must ignore.
  task automatic send_word(input wsp_in_t w);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i = 1'b0;
      in_data_i  = random_word();
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Writes a whole setting. The spare bits above the mode and the denominator carry
  // random values, and a write to a spare index comes first to show it is ignored.
  task automatic apply_setting(input weighting_t s);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
    write_reg(CFG_PRED_MODE, {6'($urandom), s.mode});
    write_reg(CFG_WEIGHT_ZERO, s.w0);
    write_reg(CFG_OFFSET_ZERO, s.o0);
    write_reg(CFG_WEIGHT_ONE, s.w1);
    write_reg(CFG_OFFSET_ONE, s.o1);
    write_reg(CFG_LOG2_DENOM, {4'($urandom), s.l2});
  endtask

  // Drops valid and waits until every expected pixel word has come back, then lets the
  // pipeline run empty before any register is touched.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Four words at the corners of the sample range: list 0 at its maximum with list 1 at
  // its minimum, the reverse, all zeros, and a word whose lanes all differ.
  task automatic send_corners();
    wsp_in_t w;
    w = {{4{16'sh7fff}}, {4{16'sh8000}}};
    send_word(w);
    w = {{4{16'sh8000}}, {4{16'sh7fff}}};
    send_word(w);
    send_word('0);
    w = {16'sh7fff, 16'sh8000, 16'shffff, 16'sh1fdf, 16'sh8000, 16'sh7fff, 16'sh0000, 16'shffdf};
    send_word(w);
  endtask

  // The receiver stalls at random, but answers each new hold ticket with one long
  // hold-off that it counts itself, so the sender fills the pipeline and sees in_stall_o.
  initial begin : receiver
    int served;
    served      = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_ticket != served) begin
        served      = hold_ticket;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i = !calm && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Ends the run when no word has moved on any channel for too long.
  initial begin : watchdog
    int still_cycles;
    still_cycles = 0;
    while (still_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
      end
    end
    $display("weighted_sample_prediction_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PRED_MODE;
    cfg_data_i  = '0;
    calm        = 1'b0;
    hold_ticket = 0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The first block of words runs on the reset values, which gives
    // default uni mode; then each mode in turn, with the explicit ones at the extreme
    // weights and offsets and at denominators of zero, fourteen and fifteen.
    send_corners();
    settle();
    apply_setting(make_setting(MODE_DEF_BI, 1, 0, 1, 0, 6));
    send_corners();
    settle();
    apply_setting(make_setting(MODE_EXP_UNI, 127, -128, -128, 127, 0));
    send_corners();
    settle();
    apply_setting(make_setting(MODE_EXP_UNI, -128, 127, 127, -128, 15));
    send_corners();
    settle();
    apply_setting(make_setting(MODE_EXP_BI, -128, 127, 127, -128, 14));
    send_corners();
    settle();
    apply_setting(make_setting(MODE_EXP_BI, 127, 127, 127, 127, 15));
    send_corners();
    settle();

    // Random part: one new setting per phase. Phase four runs without any idling on
    // either side, and phases two and eight each carry a long receiver hold-off.
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_setting(random_setting());
      calm = (p == 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ((p == 2 || p == 8) && n == 20) hold_ticket++;
        send_word(random_word());
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("weighted_sample_prediction_top regression: pass");
    end else begin
      $display("weighted_sample_prediction_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== weighted_sample_prediction_top.f =====
rtl/wsp_pkg.sv
rtl/wsp_lane.sv
rtl/wsp_merge.sv
rtl/weighted_sample_prediction_top.sv
bench/wsp_checker.sv
bench/tb_weighted_sample_prediction_top.sv
